>>> sv/cht_pkg.sv
// shared types and codes for the chained hash table unit
`timescale 1ns / 1ps

package cht_pkg;

   typedef enum logic [1:0] {
      CMD_INSERT = 2'd0,
      CMD_REMOVE = 2'd1,
      CMD_SEARCH = 2'd2,
      CMD_COUNT  = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_POOL_FULL = 2'd2,
      ST_RANGE     = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_DISPATCH,
      S_DIV,
      S_HEAD_RD,
      S_HEAD_DAT,
      S_INS_LINK,
      S_WALK_RD,
      S_WALK_DAT,
      S_UNLINK,
      S_NEWH_RD,
      S_NEWH_DAT
   } state_type;

   localparam int KEY_W   = 16;
   localparam int VALUE_W = 64;
   localparam int COUNT_W = 11;
   localparam int TSIZE_W = 7;
   localparam logic [TSIZE_W-1:0] TSIZE_RESET = 7'd64;

   typedef struct packed {
      logic       clear_wr;
      logic       latch_req;
      logic       div_start;
      logic       head_dat;
      logic       ins_alloc;
      logic       ins_link;
      logic       walk_dat;
      logic       advance;
      logic       count_inc;
      logic       unlink;
      logic       newh_sel;
      logic       rsp_write;
      status_type rsp_status;
      logic       rsp_kv;
      logic       rsp_count;
      logic       rsp_head;
   } ctrl_type;

   typedef struct packed {
      cmd_type cmd;
      logic    pool_empty;
      logic    out_of_range;
      logic    div_done;
      logic    clear_last;
      logic    cur_null;
      logic    key_match;
      logic    newh_null;
   } stat_type;

endpackage

>>> sv/cht_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps

module cht_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> sv/cht_mod.sv
// bit-serial remainder unit, one dividend bit per cycle
`timescale 1ns / 1ps

module cht_mod #(
   parameter int DW = 7
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [31:0]   dividend,
   input  logic [DW-1:0] divisor,
   output logic          done,
   output logic [DW-1:0] remainder
);

   logic [31:0]   shift_ff, shift_in;
   logic [DW:0]   rem_ff, rem_in;
   logic [DW-1:0] div_ff, div_in;
   logic [5:0]    cnt_ff, cnt_in;
   logic          run_ff, run_in;
   logic          done_ff, done_in;
   logic [DW:0]   trial;

   always_comb begin
      shift_in = shift_ff;
      rem_in   = rem_ff;
      div_in   = div_ff;
      cnt_in   = cnt_ff;
      run_in   = run_ff;
      done_in  = 1'b0;
      trial    = {rem_ff[DW-1:0], shift_ff[31]};
      if (start) begin
         shift_in = dividend;
         rem_in   = '0;
         div_in   = divisor;
         cnt_in   = '0;
         run_in   = 1'b1;
      end else if (run_ff) begin
         shift_in = {shift_ff[30:0], 1'b0};
         rem_in   = (trial >= {1'b0, div_ff}) ? trial - {1'b0, div_ff} : trial;
         cnt_in   = cnt_ff + 6'd1;
         if (cnt_ff == 6'd31) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      shift_ff <= shift_in;
      rem_ff   <= rem_in;
      div_ff   <= div_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff[DW-1:0];

endmodule

>>> sv/cht_datapath.sv
// datapath: request registers, node and bucket memories, free list, result register
`timescale 1ns / 1ps

module cht_datapath import cht_pkg::*; #(
   parameter int MAX_BUCKETS = 64,
   parameter int POOL_NODES  = 1024
) (
   input  logic                clock,
   input  logic                reset,
   input  ctrl_type            ctrl,
   output stat_type            stat,
   input  logic                csr_wr_en,
   input  logic [TSIZE_W-1:0]  csr_wr_data,
   input  logic [1:0]          req_command,
   input  logic [KEY_W-1:0]    req_key,
   input  logic [VALUE_W-1:0]  req_value,
   input  logic [5:0]          req_bucket,
   output logic                rsp_valid,
   output logic [1:0]          rsp_status,
   output logic                rsp_head_present,
   output logic [KEY_W-1:0]    rsp_found_key,
   output logic [VALUE_W-1:0]  rsp_found_value,
   output logic [COUNT_W-1:0]  rsp_chain_count,
   output logic [COUNT_W-1:0]  rsp_total_entries
);

   localparam int BW  = $clog2(MAX_BUCKETS);
   localparam int NBW = $clog2(MAX_BUCKETS + 1);
   localparam int IW  = $clog2(POOL_NODES);
   localparam int NW  = IW + 1;
   localparam int KVW = KEY_W + VALUE_W;
   localparam logic [NW-1:0] NULL_NODE = NW'(POOL_NODES);

   logic [TSIZE_W-1:0] tsize_ff;
   cmd_type            cmd_ff;
   logic [KEY_W-1:0]   key_ff;
   logic [VALUE_W-1:0] value_ff;
   logic [5:0]         bucket_ff;
   logic [BW-1:0]      b_ff, clr_ff;
   logic [NW-1:0]      head_ff, cur_ff, nx_ff, pv_ff, newh_ff, alloc_ff;
   logic [NW-1:0]      stack_ff, fresh_ff, total_ff;
   logic [COUNT_W-1:0] cnt_ff;

   logic               rsp_valid_ff;
   status_type         rsp_status_ff;
   logic               rsp_head_ff;
   logic [KEY_W-1:0]   rsp_key_ff;
   logic [VALUE_W-1:0] rsp_value_ff;
   logic [COUNT_W-1:0] rsp_count_ff;

   logic [NBW-1:0]     n_use;
   logic [31:0]        n_use32;
   logic               mod_done;
   logic [NBW-1:0]     mod_rem;
   logic [NW-1:0]      alloc_node, newh_val;
   logic               is_head;

   logic               bk_we;
   logic [BW-1:0]      bk_waddr;
   logic [NW-1:0]      bk_wdata, bk_rdata;
   logic               kv_we;
   logic [KVW-1:0]     kv_rdata;
   logic [IW-1:0]      kv_raddr;
   logic               nx_we, pv_we;
   logic [IW-1:0]      nx_waddr, pv_waddr;
   logic [NW-1:0]      nx_wdata, pv_wdata, nx_rdata, pv_rdata;
   logic [NW-1:0]      stack_dec;
   logic [IW-1:0]      fr_rdata;
   logic               fr_we;

   always_comb begin
      n_use32 = 32'(tsize_ff);
      if (n_use32 == 32'd0) begin
         n_use32 = 32'd1;
      end else if (n_use32 > 32'(MAX_BUCKETS)) begin
         n_use32 = 32'(MAX_BUCKETS);
      end
      n_use = NBW'(n_use32);
   end

   cht_mod #(.DW(NBW)) u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (ctrl.div_start),
      .dividend  ({{16{key_ff[KEY_W-1]}}, key_ff}),
      .divisor   (n_use),
      .done      (mod_done),
      .remainder (mod_rem)
   );

   assign alloc_node = (stack_ff != '0) ? {1'b0, fr_rdata} : fresh_ff;
   assign is_head    = (cur_ff == head_ff);
   assign newh_val   = is_head ? nx_ff : head_ff;
   assign stack_dec  = stack_ff - NW'(1);

   // bucket heads
   always_comb begin
      bk_we    = 1'b0;
      bk_waddr = b_ff;
      bk_wdata = NULL_NODE;
      if (ctrl.clear_wr) begin
         bk_we    = 1'b1;
         bk_waddr = clr_ff;
      end else if (ctrl.ins_alloc) begin
         bk_we    = 1'b1;
         bk_wdata = alloc_node;
      end else if (ctrl.unlink && is_head) begin
         bk_we    = 1'b1;
         bk_wdata = nx_ff;
      end
   end

   cht_ram #(.WIDTH(NW), .DEPTH(MAX_BUCKETS)) u_bucket (
      .clock (clock), .wr_en (bk_we), .wr_addr (bk_waddr), .wr_data (bk_wdata),
      .rd_addr (b_ff), .rd_data (bk_rdata)
   );

   // node key and value
   assign kv_we    = ctrl.ins_alloc;
   assign kv_raddr = ctrl.newh_sel ? newh_ff[IW-1:0] : cur_ff[IW-1:0];

   cht_ram #(.WIDTH(KVW), .DEPTH(POOL_NODES)) u_kv (
      .clock (clock), .wr_en (kv_we), .wr_addr (alloc_node[IW-1:0]),
      .wr_data ({key_ff, value_ff}), .rd_addr (kv_raddr), .rd_data (kv_rdata)
   );

   // next links
   always_comb begin
      nx_we    = 1'b0;
      nx_waddr = alloc_node[IW-1:0];
      nx_wdata = head_ff;
      if (ctrl.ins_alloc) begin
         nx_we    = 1'b1;
         nx_wdata = bk_rdata;
      end else if (ctrl.unlink && !is_head && pv_ff != NULL_NODE) begin
         nx_we    = 1'b1;
         nx_waddr = pv_ff[IW-1:0];
         nx_wdata = nx_ff;
      end
   end

   cht_ram #(.WIDTH(NW), .DEPTH(POOL_NODES)) u_next (
      .clock (clock), .wr_en (nx_we), .wr_addr (nx_waddr), .wr_data (nx_wdata),
      .rd_addr (cur_ff[IW-1:0]), .rd_data (nx_rdata)
   );

   // prev links
   always_comb begin
      pv_we    = 1'b0;
      pv_waddr = alloc_node[IW-1:0];
      pv_wdata = NULL_NODE;
      if (ctrl.ins_alloc) begin
         pv_we = 1'b1;
      end else if (ctrl.ins_link && head_ff != NULL_NODE) begin
         pv_we    = 1'b1;
         pv_waddr = head_ff[IW-1:0];
         pv_wdata = alloc_ff;
      end else if (ctrl.unlink && nx_ff != NULL_NODE) begin
         pv_we    = 1'b1;
         pv_waddr = nx_ff[IW-1:0];
         pv_wdata = is_head ? NULL_NODE : pv_ff;
      end
   end

   cht_ram #(.WIDTH(NW), .DEPTH(POOL_NODES)) u_prev (
      .clock (clock), .wr_en (pv_we), .wr_addr (pv_waddr), .wr_data (pv_wdata),
      .rd_addr (cur_ff[IW-1:0]), .rd_data (pv_rdata)
   );

   // returned nodes; never-used nodes come from the fresh counter
   assign fr_we = ctrl.unlink;

   cht_ram #(.WIDTH(IW), .DEPTH(POOL_NODES)) u_free (
      .clock (clock), .wr_en (fr_we), .wr_addr (stack_ff[IW-1:0]),
      .wr_data (cur_ff[IW-1:0]), .rd_addr (stack_dec[IW-1:0]), .rd_data (fr_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         tsize_ff     <= TSIZE_RESET;
         clr_ff       <= '0;
         stack_ff     <= '0;
         fresh_ff     <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            tsize_ff <= csr_wr_data;
         end
         if (ctrl.clear_wr) begin
            clr_ff <= clr_ff + BW'(1);
         end
         if (ctrl.ins_alloc) begin
            total_ff <= total_ff + NW'(1);
            if (stack_ff != '0) begin
               stack_ff <= stack_dec;
            end else begin
               fresh_ff <= fresh_ff + NW'(1);
            end
         end
         if (ctrl.unlink) begin
            total_ff <= total_ff - NW'(1);
            stack_ff <= stack_ff + NW'(1);
         end
         rsp_valid_ff <= ctrl.rsp_write;
      end
      if (ctrl.latch_req) begin
         cmd_ff    <= cmd_type'(req_command);
         key_ff    <= req_key;
         value_ff  <= req_value;
         bucket_ff <= req_bucket;
         b_ff      <= BW'(32'(req_bucket));
         cnt_ff    <= '0;
      end
      if (mod_done) begin
         b_ff <= BW'(32'(mod_rem));
      end
      if (ctrl.head_dat) begin
         head_ff <= bk_rdata;
         cur_ff  <= bk_rdata;
      end
      if (ctrl.ins_alloc) begin
         alloc_ff <= alloc_node;
      end
      if (ctrl.walk_dat) begin
         nx_ff <= nx_rdata;
         pv_ff <= pv_rdata;
      end
      if (ctrl.advance) begin
         cur_ff <= nx_rdata;
      end
      if (ctrl.count_inc) begin
         cnt_ff <= cnt_ff + COUNT_W'(1);
      end
      if (ctrl.unlink) begin
         newh_ff <= newh_val;
      end
      if (ctrl.rsp_write) begin
         rsp_status_ff <= ctrl.rsp_status;
         rsp_head_ff   <= ctrl.rsp_head;
         rsp_key_ff    <= ctrl.rsp_kv ? kv_rdata[KVW-1:VALUE_W] : '0;
         rsp_value_ff  <= ctrl.rsp_kv ? kv_rdata[VALUE_W-1:0] : '0;
         rsp_count_ff  <= ctrl.rsp_count ? cnt_ff : '0;
      end
   end

   always_comb begin
      stat.cmd          = cmd_ff;
      stat.pool_empty   = (stack_ff == '0) && (fresh_ff == NULL_NODE);
      stat.out_of_range = (32'(bucket_ff) >= n_use32);
      stat.div_done     = mod_done;
      stat.clear_last   = (32'(clr_ff) == 32'(MAX_BUCKETS - 1));
      stat.cur_null     = (cur_ff == NULL_NODE);
      stat.key_match    = (kv_rdata[KVW-1:VALUE_W] == key_ff);
      stat.newh_null    = (newh_ff == NULL_NODE);
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_head_present  = rsp_head_ff;
   assign rsp_found_key     = rsp_key_ff;
   assign rsp_found_value   = rsp_value_ff;
   assign rsp_chain_count   = rsp_count_ff;
   assign rsp_total_entries = COUNT_W'(32'(total_ff));

   a_pool_balance: assert property (@(posedge clock) disable iff (reset)
      32'(total_ff) + 32'(stack_ff) == 32'(fresh_ff))
      else $error("node pool bookkeeping out of balance");

   a_fresh_bound: assert property (@(posedge clock) disable iff (reset)
      32'(fresh_ff) <= 32'(POOL_NODES))
      else $error("fresh node counter past pool size");

   a_one_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |=> !rsp_valid_ff)
      else $error("result strobe held for more than one cycle");

endmodule

>>> sv/cht_ctrl.sv
// controller state machine sequencing hash, chain walk and write-back
`timescale 1ns / 1ps

module cht_ctrl import cht_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     start,
   output logic     busy,
   input  stat_type stat,
   output ctrl_type ctrl
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_CLEAR: begin
            if (stat.clear_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (start) state_in = S_DISPATCH;
         end
         S_DISPATCH: begin
            if (stat.cmd == CMD_INSERT && stat.pool_empty) begin
               state_in = S_IDLE;
            end else if (stat.cmd == CMD_COUNT) begin
               state_in = stat.out_of_range ? S_IDLE : S_HEAD_RD;
            end else begin
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            if (stat.div_done) state_in = S_HEAD_RD;
         end
         S_HEAD_RD: state_in = S_HEAD_DAT;
         S_HEAD_DAT: begin
            state_in = (stat.cmd == CMD_INSERT) ? S_INS_LINK : S_WALK_RD;
         end
         S_INS_LINK: state_in = S_IDLE;
         S_WALK_RD: begin
            state_in = stat.cur_null ? S_IDLE : S_WALK_DAT;
         end
         S_WALK_DAT: begin
            if (stat.cmd != CMD_COUNT && stat.key_match) begin
               state_in = (stat.cmd == CMD_REMOVE) ? S_UNLINK : S_IDLE;
            end else begin
               state_in = S_WALK_RD;
            end
         end
         S_UNLINK: state_in = S_NEWH_RD;
         S_NEWH_RD: begin
            state_in = stat.newh_null ? S_IDLE : S_NEWH_DAT;
         end
         S_NEWH_DAT: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      ctrl            = '0;
      ctrl.rsp_status = ST_OK;
      case (state_ff)
         S_CLEAR: ctrl.clear_wr = 1'b1;
         S_IDLE: ctrl.latch_req = start;
         S_DISPATCH: begin
            if (stat.cmd == CMD_INSERT && stat.pool_empty) begin
               ctrl.rsp_write  = 1'b1;
               ctrl.rsp_status = ST_POOL_FULL;
            end else if (stat.cmd == CMD_COUNT) begin
               if (stat.out_of_range) begin
                  ctrl.rsp_write  = 1'b1;
                  ctrl.rsp_status = ST_RANGE;
               end
            end else begin
               ctrl.div_start = 1'b1;
            end
         end
         S_HEAD_DAT: begin
            ctrl.head_dat  = 1'b1;
            ctrl.ins_alloc = (stat.cmd == CMD_INSERT);
         end
         S_INS_LINK: begin
            ctrl.ins_link  = 1'b1;
            ctrl.rsp_write = 1'b1;
         end
         S_WALK_RD: begin
            if (stat.cur_null) begin
               ctrl.rsp_write = 1'b1;
               if (stat.cmd == CMD_COUNT) begin
                  ctrl.rsp_count = 1'b1;
               end else begin
                  ctrl.rsp_status = ST_NOT_FOUND;
               end
            end
         end
         S_WALK_DAT: begin
            ctrl.walk_dat = 1'b1;
            if (stat.cmd == CMD_COUNT) begin
               ctrl.advance   = 1'b1;
               ctrl.count_inc = 1'b1;
            end else if (stat.key_match) begin
               if (stat.cmd == CMD_SEARCH) begin
                  ctrl.rsp_write = 1'b1;
                  ctrl.rsp_kv    = 1'b1;
               end
            end else begin
               ctrl.advance = 1'b1;
            end
         end
         S_UNLINK: ctrl.unlink = 1'b1;
         S_NEWH_RD: begin
            ctrl.newh_sel  = 1'b1;
            ctrl.rsp_write = stat.newh_null;
         end
         S_NEWH_DAT: begin
            ctrl.newh_sel  = 1'b1;
            ctrl.rsp_write = 1'b1;
            ctrl.rsp_kv    = 1'b1;
            ctrl.rsp_head  = 1'b1;
         end
         default: ctrl = '0;
      endcase
   end

   assign busy = (state_ff != S_IDLE);

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted transfer did not raise busy");

   a_no_write_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !ctrl.rsp_write && !ctrl.unlink && !ctrl.ins_alloc)
      else $error("table update or result while idle");

   a_clear_exit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLEAR && !stat.clear_last) |=> (state_ff == S_CLEAR))
      else $error("bucket clearing pass left early");

endmodule

>>> sv/chained_hash_table_unit.sv
// top level of the chained hash table unit
//
// Key/value table with separate chaining over a fixed node pool.
// Commands enter on start/req_* and are taken when start is high and busy
// is low; busy stays high until the result is issued. Each command gives
// exactly one result, shown on rsp_* for one cycle with rsp_valid high;
// the receiver cannot stall, so it must take every result.
// The hash remainder is worked out bit-serially, and the chain walk reads
// one node at a time through the node memories; one command is in flight
// at a time. csr_wr_en writes the bucket count from csr_wr_data; the user
// must write it only while idle, since the block itself has no check for this.
// After reset a clearing pass nulls every bucket head in turn; busy is
// high meanwhile and no command is taken.
`timescale 1ns / 1ps

module chained_hash_table_unit import cht_pkg::*; #(
   parameter int MAX_BUCKETS = 64,
   parameter int POOL_NODES  = 1024
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_wr_en,
   input  logic [TSIZE_W-1:0]  csr_wr_data,
   input  logic                start,
   output logic                busy,
   input  logic [1:0]          req_command,
   input  logic [KEY_W-1:0]    req_key,
   input  logic [VALUE_W-1:0]  req_value,
   input  logic [5:0]          req_bucket,
   output logic                rsp_valid,
   output logic [1:0]          rsp_status,
   output logic                rsp_head_present,
   output logic [KEY_W-1:0]    rsp_found_key,
   output logic [VALUE_W-1:0]  rsp_found_value,
   output logic [COUNT_W-1:0]  rsp_chain_count,
   output logic [COUNT_W-1:0]  rsp_total_entries
);

   ctrl_type ctrl;
   stat_type stat;

   cht_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .ctrl  (ctrl)
   );

   cht_datapath #(
      .MAX_BUCKETS (MAX_BUCKETS),
      .POOL_NODES  (POOL_NODES)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .ctrl              (ctrl),
      .stat              (stat),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .req_command       (req_command),
      .req_key           (req_key),
      .req_value         (req_value),
      .req_bucket        (req_bucket),
      .rsp_valid         (rsp_valid),
      .rsp_status        (rsp_status),
      .rsp_head_present  (rsp_head_present),
      .rsp_found_key     (rsp_found_key),
      .rsp_found_value   (rsp_found_value),
      .rsp_chain_count   (rsp_chain_count),
      .rsp_total_entries (rsp_total_entries)
   );

endmodule

>>> bench/chained_hash_table_unit_tb.sv
// self-checking testbench for the chained hash table unit
`timescale 1ns / 1ps

module chained_hash_table_unit_tb;
   import cht_pkg::*;

   localparam int NBUCK = 64;
   localparam int NPOOL = 1024;
   localparam int NIL = NPOOL;
   localparam int CYCLE_LIMIT = 3000000;

   typedef struct {
      status_type         status;
      logic               head_present;
      logic [KEY_W-1:0]   key;
      logic [VALUE_W-1:0] value;
      logic [COUNT_W-1:0] chain_count;
      logic [COUNT_W-1:0] total;
   } answer_type;

   logic                clock;
   logic                reset;
   logic                csr_wr_en;
   logic [TSIZE_W-1:0]  csr_wr_data;
   logic                start;
   logic                busy;
   logic [1:0]          req_command;
   logic [KEY_W-1:0]    req_key;
   logic [VALUE_W-1:0]  req_value;
   logic [5:0]          req_bucket;
   logic                rsp_valid;
   logic [1:0]          rsp_status;
   logic                rsp_head_present;
   logic [KEY_W-1:0]    rsp_found_key;
   logic [VALUE_W-1:0]  rsp_found_value;
   logic [COUNT_W-1:0]  rsp_chain_count;
   logic [COUNT_W-1:0]  rsp_total_entries;

   // table state as the unit should hold it
   int                 bucket_head [NBUCK];
   logic [KEY_W-1:0]   node_key [NPOOL];
   logic [VALUE_W-1:0] node_value [NPOOL];
   int                 node_next [NPOOL];
   int                 node_prev [NPOOL];
   int                 free_nodes [NPOOL];
   int                 free_total;
   int                 stored;
   int                 bucket_limit;

   answer_type       expected_answers [$];
   logic [KEY_W-1:0] recent_keys [$];
   int errors;
   int cycles;
   int results_seen;
   int idle_pct;
   int cmd_seen [4];
   int sizes_used;

   chained_hash_table_unit DUT (
      .clock(clock), .reset(reset),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data),
      .start(start), .busy(busy),
      .req_command(req_command), .req_key(req_key),
      .req_value(req_value), .req_bucket(req_bucket),
      .rsp_valid(rsp_valid), .rsp_status(rsp_status),
      .rsp_head_present(rsp_head_present), .rsp_found_key(rsp_found_key),
      .rsp_found_value(rsp_found_value), .rsp_chain_count(rsp_chain_count),
      .rsp_total_entries(rsp_total_entries)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic int buckets_in_use();
      if (bucket_limit == 0) return 1;
      if (bucket_limit > NBUCK) return NBUCK;
      return bucket_limit;
   endfunction

   function automatic int hash_bucket(logic [KEY_W-1:0] k);
      logic [31:0] wide;
      wide = {{16{k[15]}}, k};
      return int'(wide % 32'(buckets_in_use()));
   endfunction

   function automatic int find_key(int b, logic [KEY_W-1:0] k);
      int n;
      n = bucket_head[b];
      while (n != NIL) begin
         if (node_key[n] == k) return n;
         n = node_next[n];
      end
      return NIL;
   endfunction

   function automatic answer_type apply_command(cmd_type cmd, logic [KEY_W-1:0] k,
                                                logic [VALUE_W-1:0] v, logic [5:0] bkt);
      answer_type a;
      int b, n, h, nx, pv, c;
      a = '{ST_OK, 1'b0, '0, '0, '0, '0};
      case (cmd)
         CMD_INSERT: begin
            if (free_total == 0) begin
               a.status = ST_POOL_FULL;
            end else begin
               b = hash_bucket(k);
               free_total--;
               n = free_nodes[free_total];
               h = bucket_head[b];
               node_key[n] = k;
               node_value[n] = v;
               node_prev[n] = NIL;
               node_next[n] = h;
               if (h != NIL) node_prev[h] = n;
               bucket_head[b] = n;
               stored++;
            end
         end
         CMD_REMOVE: begin
            b = hash_bucket(k);
            n = find_key(b, k);
            if (n == NIL) begin
               a.status = ST_NOT_FOUND;
            end else begin
               nx = node_next[n];
               pv = node_prev[n];
               if (n == bucket_head[b]) begin
                  bucket_head[b] = nx;
                  if (nx != NIL) node_prev[nx] = NIL;
               end else begin
                  if (pv != NIL) node_next[pv] = nx;
                  if (nx != NIL) node_prev[nx] = pv;
               end
               free_nodes[free_total] = n;
               free_total++;
               stored--;
               if (bucket_head[b] != NIL) begin
                  a.head_present = 1'b1;
                  a.key = node_key[bucket_head[b]];
                  a.value = node_value[bucket_head[b]];
               end
            end
         end
         CMD_SEARCH: begin
            n = find_key(hash_bucket(k), k);
            if (n == NIL) begin
               a.status = ST_NOT_FOUND;
            end else begin
               a.key = node_key[n];
               a.value = node_value[n];
            end
         end
         default: begin
            if (int'(bkt) >= buckets_in_use()) begin
               a.status = ST_RANGE;
            end else begin
               c = 0;
               n = bucket_head[bkt];
               while (n != NIL) begin
                  c++;
                  n = node_next[n];
               end
               a.chain_count = COUNT_W'(c);
            end
         end
      endcase
      a.total = COUNT_W'(stored);
      return a;
   endfunction

   task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
      errors++;
      $display("mismatch on result %0d: %s got %h expected %h", results_seen, field, got, want);
   endtask

   // result checker
   always @(posedge clock) begin
      answer_type a;
      if (!reset && rsp_valid) begin
         results_seen++;
         if (expected_answers.size() == 0) begin
            errors++;
            $display("result %0d arrived with nothing expected", results_seen);
         end else begin
            a = expected_answers.pop_front();
            if (rsp_status != a.status)
               report_mismatch("status", 64'(rsp_status), 64'(a.status));
            if (rsp_head_present != a.head_present)
               report_mismatch("head_present", 64'(rsp_head_present), 64'(a.head_present));
            if (rsp_found_key != a.key)
               report_mismatch("found_key", 64'(rsp_found_key), 64'(a.key));
            if (rsp_found_value != a.value)
               report_mismatch("found_value", rsp_found_value, a.value);
            if (rsp_chain_count != a.chain_count)
               report_mismatch("chain_count", 64'(rsp_chain_count), 64'(a.chain_count));
            if (rsp_total_entries != a.total)
               report_mismatch("total_entries", 64'(rsp_total_entries), 64'(a.total));
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("chained_hash_table_unit_tb NOT OK");
         $finish;
      end
   end

   // one command transfer, then an optional idle gap
   task automatic send_item(cmd_type cmd, logic [KEY_W-1:0] k, logic [VALUE_W-1:0] v,
                            logic [5:0] bkt);
      int gap;
      req_command <= cmd;
      req_key <= k;
      req_value <= v;
      req_bucket <= bkt;
      start <= 1'b1;
      do @(posedge clock); while (busy);
      expected_answers.push_back(apply_command(cmd, k, v, bkt));
      cmd_seen[cmd]++;
      if (cmd == CMD_INSERT && recent_keys.size() < 200) recent_keys.push_back(k);
      gap = 0;
      while ($urandom_range(99) < idle_pct && gap < 12) gap++;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      start <= 1'b0;
      while (expected_answers.size() != 0 || busy) @(posedge clock);
   endtask

   task automatic write_bucket_limit(logic [TSIZE_W-1:0] sz);
      wait_drained();
      csr_wr_en <= 1'b1;
      csr_wr_data <= sz;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      bucket_limit = int'(sz);
      sizes_used++;
   endtask

   function automatic logic [VALUE_W-1:0] rand_value();
      return {$urandom, $urandom};
   endfunction

   task automatic test_directed();
      write_bucket_limit(7'd64);
      send_item(CMD_INSERT, 16'h0000, 64'h7FFF_FFFF_FFFF_FFFF, 6'd0);
      send_item(CMD_INSERT, 16'hFFFF, 64'h8000_0000_0000_0000, 6'd0);
      send_item(CMD_INSERT, 16'h7FFF, 64'hFFFF_FFFF_FFFF_FFFF, 6'd0);
      send_item(CMD_INSERT, 16'h8000, 64'h0, 6'd0);
      send_item(CMD_INSERT, 16'h0040, 64'h1234_5678_9ABC_DEF0, 6'd0);
      send_item(CMD_INSERT, 16'h0000, 64'h5555_AAAA_5555_AAAA, 6'd0);
      send_item(CMD_SEARCH, 16'h0000, 64'h0, 6'd0);
      send_item(CMD_SEARCH, 16'h1234, 64'h0, 6'd0);
      send_item(CMD_COUNT, 16'h0, 64'h0, 6'd0);
      send_item(CMD_COUNT, 16'h0, 64'h0, 6'd63);
      // middle of chain, then head, then a miss
      send_item(CMD_REMOVE, 16'h0040, 64'h0, 6'd0);
      send_item(CMD_REMOVE, 16'h0000, 64'h0, 6'd0);
      send_item(CMD_REMOVE, 16'h4321, 64'h0, 6'd0);
      send_item(CMD_REMOVE, 16'hFFFF, 64'h0, 6'd0);
      write_bucket_limit(7'd5);
      send_item(CMD_COUNT, 16'h0, 64'h0, 6'd5);
      send_item(CMD_COUNT, 16'h0, 64'h0, 6'd4);
      send_item(CMD_INSERT, 16'hFFFB, rand_value(), 6'd0);
      send_item(CMD_SEARCH, 16'h7FFF, 64'h0, 6'd0);
      write_bucket_limit(7'd0);
      send_item(CMD_COUNT, 16'h0, 64'h0, 6'd1);
      send_item(CMD_COUNT, 16'h0, 64'h0, 6'd0);
      write_bucket_limit(7'd127);
      send_item(CMD_COUNT, 16'h0, 64'h0, 6'd63);
      send_item(CMD_SEARCH, 16'h8000, 64'h0, 6'd0);
   endtask

   task automatic test_pool_full();
      logic [KEY_W-1:0] order [$];
      logic [KEY_W-1:0] k;
      write_bucket_limit(7'd64);
      while (stored < NPOOL) begin
         k = 16'($urandom);
         order.push_back(k);
         send_item(CMD_INSERT, k, rand_value(), 6'd0);
      end
      send_item(CMD_INSERT, 16'h0123, rand_value(), 6'd0);
      send_item(CMD_COUNT, 16'h0, 64'h0, 6'($urandom));
      send_item(CMD_SEARCH, order[0], 64'h0, 6'd0);
      // newest first, so every match sits at its bucket head
      while (order.size() != 0) send_item(CMD_REMOVE, order.pop_back(), 64'h0, 6'd0);
      send_item(CMD_COUNT, 16'h0, 64'h0, 6'd17);
   endtask

   task automatic test_random(int items);
      int r;
      logic [KEY_W-1:0] k;
      for (int i = 0; i < items; i++) begin
         if (recent_keys.size() != 0 && $urandom_range(99) < 65)
            k = recent_keys[$urandom_range(recent_keys.size() - 1)];
         else
            k = 16'($urandom);
         r = $urandom_range(99);
         if (r < ((stored < 120) ? 40 : 15))
            send_item(CMD_INSERT, k, rand_value(), 6'd0);
         else if (r < 65)
            send_item(CMD_REMOVE, k, rand_value(), 6'($urandom));
         else if (r < 85)
            send_item(CMD_SEARCH, k, rand_value(), 6'($urandom));
         else
            send_item(CMD_COUNT, k, rand_value(), 6'($urandom));
      end
   endtask

   task automatic test_random_phases();
      logic [TSIZE_W-1:0] sizes [8] = '{7'd64, 7'd1, 7'd13, 7'd0, 7'd100, 7'd2, 7'd37, 7'd64};
      int pcts [4] = '{0, 56, 28, 0};
      for (int p = 0; p < 8; p++) begin
         idle_pct = pcts[p % 4];
         write_bucket_limit(sizes[p]);
         test_random(70);
      end
   endtask

   initial begin
      errors = 0;
      cycles = 0;
      results_seen = 0;
      idle_pct = 0;
      sizes_used = 0;
      cmd_seen = '{0, 0, 0, 0};
      bucket_limit = 64;
      for (int i = 0; i < NBUCK; i++) bucket_head[i] = NIL;
      for (int i = 0; i < NPOOL; i++) free_nodes[i] = NPOOL - 1 - i;
      free_total = NPOOL;
      stored = 0;
      reset = 1'b1;
      start = 1'b0;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      req_command = CMD_INSERT;
      req_key = '0;
      req_value = '0;
      req_bucket = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      idle_pct = 56;
      test_pool_full();
      test_random_phases();
      wait_drained();
      repeat (60) @(posedge clock);
      $display("covered %0d results: %0d inserts, %0d removes, %0d searches, %0d counts",
               results_seen, cmd_seen[0], cmd_seen[1], cmd_seen[2], cmd_seen[3]);
      $display("over %0d bucket count writes, a full pool and idle gaps of several densities",
               sizes_used);
      if (errors == 0 && expected_answers.size() == 0) begin
         $display("chained_hash_table_unit_tb OK");
      end else begin
         $display("chained_hash_table_unit_tb NOT OK");
      end
      $finish;
   end

endmodule

>>> files.f
sv/cht_pkg.sv
sv/cht_ram.sv
sv/cht_mod.sv
sv/cht_datapath.sv
sv/cht_ctrl.sv
sv/chained_hash_table_unit.sv
bench/chained_hash_table_unit_tb.sv
